@@ hw/rtl/qhmp_pkg.sv @@
// shared types and constants for the quic header metadata parser
`default_nettype none

package qhmp_pkg;

  // longest connection id accepted
  localparam int unsigned MAX_CID = 20;

  // result kinds
  localparam logic [1:0] KIND_DCID    = 2'd0;
  localparam logic [1:0] KIND_SCID    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // summary status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FIXED_BIT = 3'd1;
  localparam logic [2:0] ST_LONG_SHORT = 3'd2;
  localparam logic [2:0] ST_DCID_BAD  = 3'd3;
  localparam logic [2:0] ST_SCID_BAD  = 3'd4;

  // first byte flags
  localparam int unsigned FORM_BIT_POS  = 7;
  localparam int unsigned FIXED_BIT_POS = 6;

  // byte position of the last version byte in a long header
  localparam logic [2:0] VERSION_END = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cid_byte;
    logic [4:0]  cid_index;
    logic        long_hdr;
    logic [31:0] version;
    logic [4:0]  dcid_length;
    logic [4:0]  scid_length;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  // up to two results raised by one input byte
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } res_pair_t;

endpackage

`default_nettype wire

@@ hw/rtl/quic_header_meta_parser.sv @@
// top level of the quic header metadata parser
//
//   channel  dir  payload                 handshake
//   byte     in   in_byte, last_byte      byte_valid / byte_stall
//   res      out  id byte or summary      res_valid / res_stall
//
// one byte word is taken per cycle while byte_stall is low; its results land in the
// queue at the same edge and leave one per cycle while res_stall is low, so a last
// byte that closes an id yields two result words. byte_stall rises when the four-entry
// queue lacks room for a pair. reset clears parser state and empties the queue.
`default_nettype none

module quic_header_meta_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire qhmp_pkg::in_word_t   byte_data,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output qhmp_pkg::out_word_t       res_data
);
  import qhmp_pkg::*;

  res_pair_t res;
  logic      take;

  assign take = byte_valid && !byte_stall;

  qhmp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (byte_data),
    .res  (res)
  );

  qhmp_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .full  (byte_stall),
    .valid (res_valid),
    .stall (res_stall),
    .data  (res_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/qhmp_parse.sv @@
// per-byte header state machine that raises id and summary results
`default_nettype none

module qhmp_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire qhmp_pkg::in_word_t word,
  output qhmp_pkg::res_pair_t     res
);
  import qhmp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_VERSION,
    PH_DLEN,
    PH_DCID,
    PH_SLEN,
    PH_SCID,
    PH_SHORT,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  position, position_next;
  logic [31:0] version_acc, version_acc_next;
  logic        form_bit, form_bit_next;
  logic [7:0]  dest_len, dest_len_next;
  logic [7:0]  src_len, src_len_next;
  logic [2:0]  err_status, err_status_next;
  logic [7:0]  id_count, id_count_next;
  logic [7:0]  id_count_inc;
  logic [7:0]  b;
  logic [2:0]  st;
  logic        bad_hdr;
  out_word_t   id_res;
  out_word_t   sum_res;

  function automatic logic [4:0] sat31(input logic [7:0] v);
    sat31 = (v > 8'd31) ? 5'd31 : v[4:0];
  endfunction

  assign b            = word.in_byte;
  assign id_count_inc = id_count + 8'd1;

  always_comb begin
    phase_next       = phase;
    version_acc_next = version_acc;
    form_bit_next    = form_bit;
    dest_len_next    = dest_len;
    src_len_next     = src_len;
    err_status_next  = err_status;
    id_count_next    = id_count;
    position_next    = (position < VERSION_END) ? position + 3'd1 : position;
    res              = '0;
    id_res           = '0;
    sum_res          = '0;
    st               = ST_OK;
    bad_hdr          = 1'b0;

    unique case (phase)
      PH_FIRST: begin
        form_bit_next = b[FORM_BIT_POS];
        if (!b[FIXED_BIT_POS]) begin
          err_status_next = ST_FIXED_BIT;
          phase_next      = PH_SKIP;
        end else if (b[FORM_BIT_POS]) begin
          phase_next = PH_VERSION;
        end else begin
          phase_next = PH_SHORT;
        end
      end
      PH_VERSION: begin
        version_acc_next = {version_acc[23:0], b};
        if (position >= VERSION_END) phase_next = PH_DLEN;
      end
      PH_DLEN: begin
        dest_len_next = b;
        id_count_next = '0;
        if (b > 8'(MAX_CID)) begin
          err_status_next = ST_DCID_BAD;
          phase_next      = PH_SKIP;
        end else begin
          phase_next = (b == 8'd0) ? PH_SLEN : PH_DCID;
        end
      end
      PH_DCID: begin
        id_res.kind      = KIND_DCID;
        id_res.cid_byte  = b;
        id_res.cid_index = id_count[4:0];
        res.count        = 2'd1;
        id_count_next    = id_count_inc;
        if (id_count_inc >= dest_len) phase_next = PH_SLEN;
      end
      PH_SLEN: begin
        src_len_next  = b;
        id_count_next = '0;
        if (b > 8'(MAX_CID)) begin
          err_status_next = ST_SCID_BAD;
          phase_next      = PH_SKIP;
        end else begin
          phase_next = (b == 8'd0) ? PH_SKIP : PH_SCID;
        end
      end
      PH_SCID: begin
        id_res.kind      = KIND_SCID;
        id_res.cid_byte  = b;
        id_res.cid_index = id_count[4:0];
        res.count        = 2'd1;
        id_count_next    = id_count_inc;
        if (id_count_inc >= src_len) phase_next = PH_SKIP;
      end
      PH_SHORT: begin
        if (dest_len < 8'(MAX_CID)) begin
          id_res.kind      = KIND_DCID;
          id_res.cid_byte  = b;
          id_res.cid_index = id_count[4:0];
          res.count        = 2'd1;
          id_count_next    = id_count_inc;
          dest_len_next    = dest_len + 8'd1;
        end
        if (dest_len_next >= 8'(MAX_CID)) phase_next = PH_SKIP;
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    id_res.long_hdr = form_bit_next;

    // status from where the datagram stopped
    st = err_status_next;
    if (st == ST_OK) begin
      if (phase_next == PH_VERSION || phase_next == PH_DLEN) begin
        st = ST_LONG_SHORT;
      end else if (phase_next == PH_DCID || phase_next == PH_SLEN) begin
        st = ST_DCID_BAD;
      end else if (phase_next == PH_SCID) begin
        st = ST_SCID_BAD;
      end
    end
    bad_hdr = (st == ST_FIXED_BIT) || (st == ST_LONG_SHORT);

    sum_res.kind        = KIND_SUMMARY;
    sum_res.long_hdr    = form_bit_next;
    sum_res.version     = bad_hdr ? '0 : version_acc_next;
    sum_res.dcid_length = bad_hdr ? '0 : sat31(dest_len_next);
    sum_res.scid_length = bad_hdr ? '0 : sat31(src_len_next);
    sum_res.status      = st;
    sum_res.last        = 1'b1;

    res.first = id_res;
    if (word.last_byte) begin
      if (res.count == 2'd1) begin
        res.second = sum_res;
        res.count  = 2'd2;
      end else begin
        res.first = sum_res;
        res.count = 2'd1;
      end
      // datagram done, back to the start
      phase_next       = PH_FIRST;
      position_next    = '0;
      version_acc_next = '0;
      form_bit_next    = 1'b0;
      dest_len_next    = '0;
      src_len_next     = '0;
      err_status_next  = ST_OK;
      id_count_next    = '0;
    end

    if (!take) res.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      position    <= '0;
      version_acc <= '0;
      form_bit    <= 1'b0;
      dest_len    <= '0;
      src_len     <= '0;
      err_status  <= ST_OK;
      id_count    <= '0;
    end else if (take) begin
      phase       <= phase_next;
      position    <= position_next;
      version_acc <= version_acc_next;
      form_bit    <= form_bit_next;
      dest_len    <= dest_len_next;
      src_len     <= src_len_next;
      err_status  <= err_status_next;
      id_count    <= id_count_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qhmp_resq.sv @@
// four-entry result queue, two writes and one read per cycle
`default_nettype none

module qhmp_resq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qhmp_pkg::res_pair_t res,
  output logic                     full,
  output logic                     valid,
  input  wire logic                stall,
  output qhmp_pkg::out_word_t      data
);
  import qhmp_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  out_word_t          slots [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_inc;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign valid      = (count != '0);
  assign data       = slots[rd_ptr];
  assign pop        = valid && !stall;
  // room is needed for a full pair before the next word is taken
  assign full       = (count > CNT_W'(QDEPTH - 2));
  assign wr_ptr_inc = wr_ptr + PTR_W'(1);
  assign count_next = count + CNT_W'(res.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) slots[wr_ptr] <= res.first;
    if (res.count == 2'd2) slots[wr_ptr_inc] <= res.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(res.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the quic header metadata parser
`timescale 1ns / 100ps

module testbench;
  import qhmp_pkg::*;

  localparam int unsigned BYTES_WANTED = 1150;

  typedef enum logic [2:0] {
    P_FIRST, P_VER, P_DLEN, P_DID, P_SLEN, P_SID, P_SHORT, P_SKIP
  } parse_phase_t;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         typed;
    out_word_t  want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_data = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_data;

  // parser state as the predictor tracks it
  parse_phase_t ps;
  logic [15:0]  pos;
  logic [31:0]  ver_acc;
  logic         form;
  logic [7:0]   dlen;
  logic [7:0]   slen;
  logic [2:0]   err;
  logic [7:0]   idn;

  out_word_t fresh[$];
  out_word_t expected_results[$];
  row_t      rows[$];
  logic [7:0] dg[$];

  bit          calm = 1'b0;
  int unsigned fails = 0;
  int unsigned results_checked = 0;
  int unsigned header_bytes = 0;
  int unsigned bytes_sent = 0;
  int unsigned dgrams_sent = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  quic_header_meta_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #10 clk = ~clk;

  function automatic logic [4:0] sat31(input logic [7:0] v);
    return (v > 8'd31) ? 5'd31 : v[4:0];
  endfunction

  function automatic out_word_t id_word(input logic [1:0] k, input logic [7:0] b,
                                        input logic [7:0] idx);
    out_word_t w;
    w = '0;
    w.kind      = k;
    w.cid_byte  = b;
    w.cid_index = idx[4:0];
    w.long_hdr  = form;
    return w;
  endfunction

  function automatic out_word_t summary_word(input logic f, input logic [31:0] ver,
                                             input logic [4:0] dl, input logic [4:0] sl,
                                             input logic [2:0] st);
    out_word_t w;
    w = '0;
    w.kind        = KIND_SUMMARY;
    w.long_hdr    = f;
    w.version     = ver;
    w.dcid_length = dl;
    w.scid_length = sl;
    w.status      = st;
    w.last        = 1'b1;
    return w;
  endfunction

  function automatic void clear_parser();
    ps      = P_FIRST;
    pos     = '0;
    ver_acc = '0;
    form    = 1'b0;
    dlen    = '0;
    slen    = '0;
    err     = ST_OK;
    idn     = '0;
  endfunction

  // advances the predicted parser by one byte, leaving its results in fresh
  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic [2:0] st;
    if (ps != P_SKIP) header_bytes++;
    case (ps)
      P_FIRST: begin
        form = b[FORM_BIT_POS];
        if (!b[FIXED_BIT_POS]) begin
          err = ST_FIXED_BIT;
          ps  = P_SKIP;
        end else if (form) begin
          ps = P_VER;
        end else begin
          ps = P_SHORT;
        end
      end
      P_VER: begin
        ver_acc = {ver_acc[23:0], b};
        if (pos >= 16'd4) ps = P_DLEN;
      end
      P_DLEN: begin
        dlen = b;
        idn  = '0;
        if (b > 8'(MAX_CID)) begin
          err = ST_DCID_BAD;
          ps  = P_SKIP;
        end else begin
          ps = (b == 8'd0) ? P_SLEN : P_DID;
        end
      end
      P_DID: begin
        fresh.push_back(id_word(KIND_DCID, b, idn));
        idn++;
        if (idn >= dlen) ps = P_SLEN;
      end
      P_SLEN: begin
        slen = b;
        idn  = '0;
        if (b > 8'(MAX_CID)) begin
          err = ST_SCID_BAD;
          ps  = P_SKIP;
        end else begin
          ps = (b == 8'd0) ? P_SKIP : P_SID;
        end
      end
      P_SID: begin
        fresh.push_back(id_word(KIND_SCID, b, idn));
        idn++;
        if (idn >= slen) ps = P_SKIP;
      end
      P_SHORT: begin
        if (dlen < 8'(MAX_CID)) begin
          fresh.push_back(id_word(KIND_DCID, b, idn));
          idn++;
          dlen++;
        end
        if (dlen >= 8'(MAX_CID)) ps = P_SKIP;
      end
      default: ;
    endcase
    if (pos != 16'hFFFF) pos++;
    if (fin) begin
      st = err;
      if (st == ST_OK) begin
        case (ps)
          P_VER, P_DLEN: st = ST_LONG_SHORT;
          P_DID, P_SLEN: st = ST_DCID_BAD;
          P_SID:         st = ST_SCID_BAD;
          default: ;
        endcase
      end
      // a broken first byte or a cut version hides everything but the form and the status
      if (st == ST_FIXED_BIT || st == ST_LONG_SHORT)
        fresh.push_back(summary_word(form, 32'd0, 5'd0, 5'd0, st));
      else
        fresh.push_back(summary_word(form, ver_acc, sat31(dlen), sat31(slen), st));
      clear_parser();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_CID) : $urandom_range(0, 4);
  endfunction

  // long header into dg; bad_id 1 spoils the destination length, 2 the source one
  function automatic void build_long(input int bad_id);
    int unsigned n;
    dg.push_back({2'b11, 6'($urandom)});
    repeat (4) dg.push_back(8'($urandom));
    n = (bad_id == 1) ? $urandom_range(MAX_CID + 1, 255) : pick_len();
    dg.push_back(8'(n));
    if (bad_id != 1) begin
      repeat (n) dg.push_back(8'($urandom));
      n = (bad_id == 2) ? $urandom_range(MAX_CID + 1, 255) : pick_len();
      dg.push_back(8'(n));
      if (bad_id != 2) repeat (n) dg.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 4)) dg.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input out_word_t want);
    if (!calm)
      while ($urandom_range(0, 99) < 33) begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
    byte_valid <= 1'b1;
    byte_data  <= '{in_byte: b, last_byte: fin};
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    parse_byte(b, fin);
    if (typed) begin
      fresh.delete();
      expected_results.push_back(want);
    end else begin
      while (fresh.size() != 0) expected_results.push_back(fresh.pop_front());
    end
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // result side: check each accepted word, stall at random, one long hold-off
  always @(posedge clk) begin
    if (res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d", res_data.kind);
        fails++;
      end else begin
        out_word_t want;
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(res_data.kind));
        check_field("cid_byte", 32'(want.cid_byte), 32'(res_data.cid_byte));
        check_field("cid_index", 32'(want.cid_index), 32'(res_data.cid_index));
        check_field("long_hdr", 32'(want.long_hdr), 32'(res_data.long_hdr));
        check_field("version", want.version, res_data.version);
        check_field("dcid_length", 32'(want.dcid_length), 32'(res_data.dcid_length));
        check_field("scid_length", 32'(want.scid_length), 32'(res_data.scid_length));
        check_field("status", 32'(want.status), 32'(res_data.status));
        check_field("last", 32'(want.last), 32'(res_data.last));
      end
      results_checked++;
    end
    if (!held && results_checked >= 150) begin
      held      = 1'b1;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned cut;
    logic [7:0] first;
    clear_parser();

    // single-byte datagrams, oversize lengths, cut inside an id
    rows.push_back('{8'h00, 1'b1, 1'b1, summary_word(1'b0, 32'd0, 5'd0, 5'd0, ST_FIXED_BIT)});
    rows.push_back('{8'hBF, 1'b1, 1'b1, summary_word(1'b1, 32'd0, 5'd0, 5'd0, ST_FIXED_BIT)});
    rows.push_back('{8'hFF, 1'b1, 1'b1, summary_word(1'b1, 32'd0, 5'd0, 5'd0, ST_LONG_SHORT)});
    rows.push_back('{8'h40, 1'b1, 1'b1, summary_word(1'b0, 32'd0, 5'd0, 5'd0, ST_OK)});
    rows.push_back('{8'hC0, 1'b0, 1'b0, '0});
    repeat (4) rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b1, 1'b1,
                     summary_word(1'b1, 32'hFFFF_FFFF, 5'd31, 5'd0, ST_DCID_BAD)});
    rows.push_back('{8'hC0, 1'b0, 1'b0, '0});
    repeat (3) rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h15, 1'b1, 1'b1, summary_word(1'b1, 32'd1, 5'd0, 5'd21, ST_SCID_BAD)});
    rows.push_back('{8'hC0, 1'b0, 1'b0, '0});
    repeat (4) rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    rows.push_back('{8'hAB, 1'b1, 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].typed, rows[i].want);
    drain();

    while (bytes_sent < BYTES_WANTED) begin
      calm = (dgrams_sent >= 12 && dgrams_sent < 20);
      if (dgrams_sent == 30) drain();
      dg.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        build_long(0);
      end else if (r < 70) begin
        dg.push_back({2'b01, 6'($urandom)});
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(18, 26) : $urandom_range(0, 6))
          dg.push_back(8'($urandom));
      end else if (r < 80) begin
        build_long($urandom_range(1, 2));
      end else if (r < 90) begin
        // well-formed long header, possibly cut short at a random byte
        build_long(0);
        cut = $urandom_range(1, dg.size());
        while (dg.size() > cut) void'(dg.pop_back());
      end else begin
        first = 8'($urandom);
        if ($urandom_range(0, 1) == 1) first[FIXED_BIT_POS] = 1'b0;
        dg.push_back(first);
        repeat ($urandom_range(0, 5)) dg.push_back(8'($urandom));
      end
      foreach (dg[i]) send_byte(dg[i], i == dg.size() - 1, 1'b0, '0);
      dgrams_sent++;
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("directed table of %0d bytes plus %0d random datagrams (long, short, cut, ",
             rows.size(), dgrams_sent);
    $display("oversize ids, noise): %0d bytes in, %0d header bytes, %0d result words checked",
             bytes_sent, header_bytes, results_checked);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
